// File: rtl/core/cht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and codes of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 12;

    localparam logic [6:0] BUCKET_COUNT_RESET = 7'd64;

    // Register index of bucket_count
    localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

    // Classified request from the front end
    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [SUM_W-1:0]   sum;
    } req_t;

endpackage : cht_pkg
`default_nettype wire

// File: rtl/core/cht_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_front
// Accept requests, normalise the key, sum its bytes and queue the request.
// ----------------------------------------------------------------------------
module cht_front #(
    parameter int KEY_BYTES = 8,
    parameter int QDEPTH    = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_action,
    input  wire logic [63:0]      s_key,
    input  wire logic [31:0]      s_value,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output cht_pkg::req_t         q_req
);
    localparam int QA = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    cht_pkg::req_t    mem_reg [QDEPTH];
    logic [QA-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [QA:0]      cnt_reg, cnt_next;
    logic [63:0]      nkey;
    logic [cht_pkg::SUM_W-1:0] sum;
    logic             stop;
    cht_pkg::req_t    req;
    logic             push, pop;

    // Normalise key: cut at first NUL or KEY_BYTES
    always_comb begin
        nkey = '0;
        stop = 1'b0;
        sum  = cht_pkg::SUM_W'(1);
        for (int i = 0; i < 8; i++) begin
            if (i < KEY_BYTES && !stop && s_key[8*i +: 8] != 8'd0) begin
                nkey[8*i +: 8] = s_key[8*i +: 8];
                sum = sum + cht_pkg::SUM_W'(s_key[8*i +: 8]);
            end else begin
                stop = 1'b1;
            end
        end
        req.action = cht_pkg::action_t'(s_action);
        req.key    = nkey;
        req.value  = s_value;
        req.sum    = sum;
    end

    assign s_ready = (cnt_reg != (QA+1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_req   = mem_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Advance queue pointers
    always_comb begin
        wr_next  = push ? ((wr_reg == QA'(QDEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? ((rd_reg == QA'(QDEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (QA+1)'(push) - (QA+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= req;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QA+1)'(QDEPTH)) else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue push lost");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> !q_valid) else $error("empty queue presents request");

endmodule : cht_front
`default_nettype wire

// File: rtl/core/cht_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_back
// Carry out queued requests: hash, walk the chain, update entries and heads.
// ----------------------------------------------------------------------------
module cht_back #(
    parameter int BUCKETS      = 64,
    parameter int POOL_ENTRIES = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [6:0]       bucket_count,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire cht_pkg::req_t    q_req,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_found,
    output logic [31:0]           m_value_out,
    output logic                  m_pool_full,
    output logic                  busy
);
    localparam int BA = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EA = $clog2(POOL_ENTRIES);
    localparam int PW = EA + 1;
    localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);
    localparam int SW = cht_pkg::SUM_W;
    localparam int NW = (BA + 1 > 7) ? BA + 1 : 7;
    localparam int CW = (BUCKETS > POOL_ENTRIES) ? BUCKETS : POOL_ENTRIES;
    localparam int CA = $clog2(CW);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_MOD   = 11'b00000000010,
        ST_HEAD  = 11'b00000000100,
        ST_READ  = 11'b00000001000,
        ST_CMP   = 11'b00000010000,
        ST_ALLOC = 11'b00000100000,
        ST_WRITE = 11'b00001000000,
        ST_CLEAR = 11'b00010000000,
        ST_OUT   = 11'b00100000000,
        ST_SKIP  = 11'b01000000000,
        ST_PICK  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Stores
    logic [63:0]   ekey_mem [POOL_ENTRIES];
    logic [31:0]   eval_mem [POOL_ENTRIES];
    logic [PW-1:0] enext_mem [POOL_ENTRIES];
    logic [PW-1:0] head_reg [BUCKETS];
    logic          used_reg [POOL_ENTRIES];

    cht_pkg::req_t req_reg;
    logic [SW-1:0] rem_reg;
    logic [NW-1:0] n_reg;
    logic [BA-1:0] b_reg;
    logic [PW-1:0] cur_reg, prev_reg;
    logic [PW:0]   steps_reg;
    logic [63:0]   rkey_reg;
    logic [31:0]   rval_reg;
    logic [PW-1:0] rnext_reg;
    logic [PW-1:0] scan_reg;
    logic          free_reg;
    logic [CA-1:0] clr_reg;
    logic          boot_reg;
    logic          outv_reg, found_reg, full_reg;
    logic [31:0]   vout_reg;
    logic [EA-1:0] cidx;

    assign cidx = cur_reg[EA-1:0];
    assign q_ready = (state_reg == ST_IDLE) && !outv_reg;
    assign m_valid = outv_reg;
    assign m_found = found_reg;
    assign m_value_out = vout_reg;
    assign m_pool_full = full_reg;
    assign busy = (state_reg != ST_IDLE) || outv_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_valid && q_ready) begin
                state_next = (q_req.action == cht_pkg::ACT_CLEAR) ? ST_CLEAR : ST_MOD;
            end
            ST_MOD:   if (rem_reg < SW'(n_reg)) state_next = ST_HEAD;
            ST_HEAD:  state_next = ST_READ;
            ST_READ:  state_next = (cur_reg == NIL) ? ST_ALLOC : ST_CMP;
            ST_CMP:   state_next = ST_SKIP;
            ST_SKIP:  state_next = ST_READ;
            ST_ALLOC: state_next = ST_PICK;
            ST_PICK:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_CLEAR: state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: chain walk one entry per read, modulo by repeated subtract
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            outv_reg  <= 1'b0;
            clr_reg   <= '0;
            boot_reg  <= 1'b1;
        end else begin
            if (outv_reg && m_ready) outv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_ready) begin
                        req_reg   <= q_req;
                        rem_reg   <= q_req.sum;
                        found_reg <= 1'b0;
                        full_reg  <= 1'b0;
                        vout_reg  <= '0;
                        steps_reg <= '0;
                        prev_reg  <= NIL;
                        clr_reg   <= '0;
                        if (bucket_count == 7'd0) n_reg <= NW'(1);
                        else if (NW'(bucket_count) > NW'(BUCKETS)) n_reg <= NW'(BUCKETS);
                        else n_reg <= NW'(bucket_count);
                        state_reg <= state_next;
                    end
                end
                ST_MOD: begin
                    if (rem_reg < SW'(n_reg)) b_reg <= rem_reg[BA-1:0];
                    else rem_reg <= rem_reg - SW'(n_reg);
                    state_reg <= state_next;
                end
                ST_HEAD: begin
                    cur_reg   <= head_reg[b_reg];
                    state_reg <= state_next;
                end
                ST_READ: begin
                    if (cur_reg != NIL) begin
                        rkey_reg  <= ekey_mem[cidx];
                        rval_reg  <= eval_mem[cidx];
                        rnext_reg <= enext_mem[cidx];
                    end
                    scan_reg  <= '0;
                    state_reg <= state_next;
                end
                ST_CMP: begin
                    if (rkey_reg == req_reg.key) begin
                        found_reg <= 1'b1;
                        case (req_reg.action)
                            cht_pkg::ACT_LOOKUP: vout_reg <= rval_reg;
                            cht_pkg::ACT_INSERT: ;
                            cht_pkg::ACT_DELETE: begin
                                if (prev_reg == NIL) head_reg[b_reg] <= rnext_reg;
                                used_reg[cidx] <= 1'b0;
                            end
                            default: ;
                        endcase
                        state_reg <= ST_WRITE;
                    end else if (steps_reg + 1'b1 >= (PW+1)'(POOL_ENTRIES)) begin
                        // Walk limit reached: treat the key as absent
                        state_reg <= ST_ALLOC;
                    end else begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= rnext_reg;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= state_next;
                    end
                end
                ST_SKIP: state_reg <= state_next;
                ST_ALLOC: begin
                    // Read the in-use flag of the next candidate entry
                    if (req_reg.action != cht_pkg::ACT_INSERT) begin
                        state_reg <= ST_OUT;
                    end else if (scan_reg == NIL) begin
                        full_reg  <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        free_reg  <= !used_reg[scan_reg[EA-1:0]];
                        state_reg <= state_next;
                    end
                end
                ST_PICK: begin
                    // Take the candidate if free, else move to the next one
                    if (free_reg) begin
                        used_reg[scan_reg[EA-1:0]] <= 1'b1;
                        head_reg[b_reg] <= scan_reg;
                        state_reg <= state_next;
                    end else begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= ST_ALLOC;
                    end
                end
                ST_WRITE: state_reg <= state_next;
                ST_CLEAR: begin
                    // Clearing pass: one bucket head and one pool flag per cycle
                    if (int'(clr_reg) < BUCKETS) head_reg[clr_reg[BA-1:0]] <= NIL;
                    if (int'(clr_reg) < POOL_ENTRIES) used_reg[clr_reg[EA-1:0]] <= 1'b0;
                    if (clr_reg == CA'(CW-1)) begin
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? ST_IDLE : state_next;
                    end else begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    outv_reg  <= 1'b1;
                    state_reg <= state_next;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Entry memory writes
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PICK && free_reg) begin
            ekey_mem[scan_reg[EA-1:0]]  <= req_reg.key;
            eval_mem[scan_reg[EA-1:0]]  <= req_reg.value;
            enext_mem[scan_reg[EA-1:0]] <= head_reg[b_reg];
        end else if (state_reg == ST_CMP && rkey_reg == req_reg.key) begin
            if (req_reg.action == cht_pkg::ACT_INSERT) eval_mem[cidx] <= req_reg.value;
            else if (req_reg.action == cht_pkg::ACT_DELETE && prev_reg != NIL)
                enext_mem[prev_reg[EA-1:0]] <= rnext_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_pool_full)) else $error("found with full");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_valid) else $error("result not raised");

endmodule : cht_back
`default_nettype wire

// File: rtl/core/chained_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table
// Key-value table with chained buckets in a fixed entry pool.
// ----------------------------------------------------------------------------
// A request finds its bucket by subtracting bucket_count from the key's byte
// sum until it is smaller, then walks the bucket's chain one entry at a time;
// a new insert searches the pool for the lowest free entry. Clear runs a
// clearing pass over the larger of BUCKETS and POOL_ENTRIES; the same pass
// runs after reset, and no request is carried out until it ends. A two-deep
// queue lets requests be taken while one is in progress.
module chained_hash_table #(
    parameter int BUCKETS      = 64,
    parameter int POOL_ENTRIES = 256,
    parameter int KEY_BYTES    = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [63:0] s_key,
    input  wire logic [31:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [31:0]      m_value_out,
    output logic             m_pool_full
);
    logic [6:0]     bucket_count_reg;
    logic           q_valid, q_ready, busy;
    cht_pkg::req_t  q_req;

    assign pready = 1'b1;
    assign prdata = (paddr[1] == cht_pkg::REG_BUCKET_COUNT) ?
                    {25'd0, bucket_count_reg} : 32'd0;

    // Hold bucket_count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= cht_pkg::BUCKET_COUNT_RESET;
        end else if (psel && penable && pwrite && paddr[1] == cht_pkg::REG_BUCKET_COUNT) begin
            bucket_count_reg <= pwdata[6:0];
        end
    end

    cht_front #(.KEY_BYTES(KEY_BYTES), .QDEPTH(2)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .s_key, .s_value,
        .q_valid, .q_ready, .q_req
    );

    cht_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
        .aclk, .aresetn, .bucket_count(bucket_count_reg), .q_valid, .q_ready,
        .q_req, .m_valid, .m_ready, .m_found, .m_value_out, .m_pool_full, .busy
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy |-> !m_valid) else $error("result while idle");

endmodule : chained_hash_table
`default_nettype wire
